@@ rtl/core/jacobi_symbol_defines.svh @@
// Assertion macros shared by the Jacobi symbol RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef JACOBI_SYMBOL_DEFINES_SVH
`define JACOBI_SYMBOL_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define JS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/js_pkg.sv @@
// Package for the Jacobi symbol block: symbol codes, residue constants and
// the command and status structs between controller and datapath. No dependencies.
package js_pkg;

   localparam logic signed [1:0] SYM_ZERO = 2'sb00;
   localparam logic signed [1:0] SYM_POS  = 2'sb01;
   localparam logic signed [1:0] SYM_NEG  = 2'sb11;

   localparam logic [2:0] RES8_THREE = 3'd3;
   localparam logic [2:0] RES8_FIVE  = 3'd5;

   typedef struct packed {
      logic load;
      logic shift;
      logic div_start;
      logic div_step;
      logic commit;
      logic publish;
   } js_cmd_type;

   typedef struct packed {
      logic a_zero;
      logic a_odd;
      logic b_even;
      logic cnt_last;
      logic out_free;
   } js_status_type;

endpackage

@@ rtl/core/js_if.sv @@
// Valid/ready channel interfaces for the Jacobi symbol block.
// Depends on nothing; used by the top level.
interface js_req_if #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] top_value;
   logic [WIDTH-1:0] modulus;

   modport source (output valid, output top_value, output modulus, input ready);
   modport sink (input valid, input top_value, input modulus, output ready);
endinterface

interface js_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [1:0] symbol;
   logic              bad_modulus;

   modport source (output valid, output symbol, output bad_modulus, input ready);
   modport sink (input valid, input symbol, input bad_modulus, output ready);
endinterface

@@ rtl/core/jacobi_symbol.sv @@
// Jacobi symbol (a/b) of an unsigned numerator and an odd denominator, by binary
// reciprocity. One transaction is in work at a time. Each round strips one factor
// of two per cycle from the numerator, then reduces the denominator modulo the
// numerator on a restoring remainder unit that steps through all WIDTH bits of the
// denominator, with a check of the numerator between rounds. An even or zero
// modulus gives 0 with bad_modulus set. A finished result waits in the output
// register while the next transaction is accepted.
// Depends on js_pkg, js_if, js_ctrl and js_dp.
module jacobi_symbol #(
   parameter int WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   js_req_if.sink    req_bus,
   js_rsp_if.source  rsp_bus
);
   import js_pkg::*;

   js_cmd_type    cmd;
   js_status_type status;

   js_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   js_dp #(.WIDTH(WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .top_value   (req_bus.top_value),
      .modulus     (req_bus.modulus),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .symbol      (rsp_bus.symbol),
      .bad_modulus (rsp_bus.bad_modulus)
   );

endmodule

@@ rtl/core/js_ctrl.sv @@
// Controller state machine for the Jacobi symbol block.
// Depends on js_pkg and jacobi_symbol_defines.svh.
`include "jacobi_symbol_defines.svh"

module js_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  js_pkg::js_status_type status,
   output js_pkg::js_cmd_type    cmd
);
   import js_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DIVIDE, ST_FINISH} state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.b_even || status.a_zero) begin
               state_in = ST_FINISH;
            end else if (!status.a_odd) begin
               cmd.shift = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.cnt_last) begin
               cmd.commit = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `JS_ASSERT_NEXT(a_load_to_check, clock, reset, cmd.load, state_ff == ST_CHECK,
      "A loaded transaction did not enter the check state.")
   `JS_ASSERT_NEXT(a_div_done, clock, reset, state_ff == ST_DIVIDE && status.cnt_last,
      state_ff == ST_CHECK, "The reduction did not return to the check state.")
   `JS_ASSERT_NOW(a_publish_free, clock, reset, cmd.publish, status.out_free,
      "A result was published while the output register was occupied.")

endmodule

@@ rtl/core/js_dp.sv @@
// Datapath for the Jacobi symbol block: operand registers, sign flag,
// restoring remainder unit and the result register. Depends on js_pkg and jacobi_symbol_defines.svh.
`include "jacobi_symbol_defines.svh"

module js_dp #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  js_pkg::js_cmd_type    cmd,
   output js_pkg::js_status_type status,
   input  logic [WIDTH-1:0]      top_value,
   input  logic [WIDTH-1:0]      modulus,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [1:0]     symbol,
   output logic                  bad_modulus
);
   import js_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);

   logic [WIDTH-1:0] a_ff, b_ff, rem_ff, dvd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             flip_ff;
   logic             rsp_valid_ff;
   logic signed [1:0] symbol_ff;
   logic             bad_ff;

   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   rem_diff;
   logic [WIDTH-1:0] rem_next;
   logic             b_res35;
   logic signed [1:0] symbol_in;

   assign rem_shift = {rem_ff, dvd_ff[WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, a_ff};
   assign rem_next  = rem_diff[WIDTH] ? rem_shift[WIDTH-1:0] : rem_diff[WIDTH-1:0];
   assign b_res35   = (b_ff[2:0] == RES8_THREE) || (b_ff[2:0] == RES8_FIVE);

   always_comb begin
      if (!b_ff[0] || b_ff != WIDTH'(1)) begin
         symbol_in = SYM_ZERO;
      end else if (flip_ff) begin
         symbol_in = SYM_NEG;
      end else begin
         symbol_in = SYM_POS;
      end
   end

   assign status.a_zero   = (a_ff == '0);
   assign status.a_odd    = a_ff[0];
   assign status.b_even   = !b_ff[0];
   assign status.cnt_last = (cnt_ff == CNT_W'(WIDTH - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff    <= top_value;
         b_ff    <= modulus;
         flip_ff <= 1'b0;
      end else if (cmd.shift) begin
         a_ff    <= {1'b0, a_ff[WIDTH-1:1]};
         flip_ff <= flip_ff ^ b_res35;
      end else if (cmd.div_start) begin
         flip_ff <= flip_ff ^ (a_ff[1] & b_ff[1]);
         rem_ff  <= '0;
         dvd_ff  <= b_ff;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_next;
         dvd_ff <= {dvd_ff[WIDTH-2:0], 1'b0};
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cmd.commit) begin
            a_ff <= rem_next;
            b_ff <= a_ff;
         end
      end
      if (cmd.publish) begin
         symbol_ff <= symbol_in;
         bad_ff    <= !b_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign symbol      = symbol_ff;
   assign bad_modulus = bad_ff;

   `JS_ASSERT_NOW(a_divisor_nonzero, clock, reset, cmd.div_step, a_ff != '0,
      "The remainder unit ran with a zero divisor.")
   `JS_ASSERT_NEXT(a_commit_swap, clock, reset, cmd.commit, b_ff == $past(a_ff),
      "The denominator was not replaced by the old numerator.")
   `JS_ASSERT_NOW(a_bad_zero, clock, reset, rsp_valid_ff && bad_ff, symbol_ff == SYM_ZERO,
      "A result with a bad modulus carries a nonzero symbol.")

endmodule
